FILE: src/clbm_pkg.sv
// Shared types, operation codes and command codes of the chunked list buffer manager.
`timescale 1ns / 1ps

package clbm_pkg;

    localparam int POOL_CHUNKS_DEF = 64;
    localparam int CHUNK_SIZE_DEF  = 16;
    localparam int NUM_LISTS_DEF   = 16;
    localparam int LEN_W           = 11;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [4:0] CMD_NOP        = 5'd0;
    localparam logic [4:0] CMD_LOAD       = 5'd1;
    localparam logic [4:0] CMD_PUSH_START = 5'd2;
    localparam logic [4:0] CMD_PUSH_FIRST = 5'd3;
    localparam logic [4:0] CMD_PUSH_CHECK = 5'd4;
    localparam logic [4:0] CMD_PUSH_LINK  = 5'd5;
    localparam logic [4:0] CMD_PUSH_NEW   = 5'd6;
    localparam logic [4:0] CMD_PUSH_WRITE = 5'd7;
    localparam logic [4:0] CMD_POP_START  = 5'd8;
    localparam logic [4:0] CMD_POP_TAKE   = 5'd9;
    localparam logic [4:0] CMD_POP_READ   = 5'd10;
    localparam logic [4:0] CMD_POP_FIX    = 5'd11;
    localparam logic [4:0] CMD_GET_START  = 5'd12;
    localparam logic [4:0] CMD_GET_STEP   = 5'd13;
    localparam logic [4:0] CMD_GET_READ   = 5'd14;
    localparam logic [4:0] CMD_CLR_START  = 5'd15;
    localparam logic [4:0] CMD_CLR_STEP   = 5'd16;
    localparam logic [4:0] CMD_EMIT       = 5'd17;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  list_id;
        logic [31:0] push_value;
        logic [9:0]  element_index;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [31:0]      read_value;
        logic [LEN_W-1:0] list_length;
    } rsp_t;

    typedef struct packed {
        logic [4:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       id_ok;
        logic       has_last;
        logic       has_first;
        logic       fh_chunk;
        logic       count_zero;
        logic       idx_ok;
        logic       rd_full;
        logic       rd_fill_zero;
        logic       fix;
        logic       get_hit;
        logic       has_next;
        logic       out_free;
    } sts_t;

endpackage

FILE: src/chunked_list_buffer_manager_core.sv
// Top level of the chunked list buffer manager.
`timescale 1ns / 1ps

// Keeps NUM_LISTS lists of 32-bit words in a shared pool of POOL_CHUNKS chunks of
// CHUNK_SIZE words, with one result item for every request item. One request is
// worked on at a time; a finished result waits in an output register while the next
// request is taken. A push links a new chunk when the last chunk is full; a pop
// unlinks the previous chunk when its chunk empties; a get walks past chunks until
// it reaches the indexed word; a clear frees the chunks of the list one by one. A
// request can fail at dispatch, and a push into a full chunk fails when the pool is
// empty. The next request is accepted only after the result is presented, and a
// result is held back while the previous one has not been taken. Each step of a
// chain walk uses the single registered read port of the chunk metadata memory in
// turn.
module chunked_list_buffer_manager_core #(
    parameter int POOL_CHUNKS = clbm_pkg::POOL_CHUNKS_DEF,
    parameter int CHUNK_SIZE  = clbm_pkg::CHUNK_SIZE_DEF,
    parameter int NUM_LISTS   = clbm_pkg::NUM_LISTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  clbm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output clbm_pkg::rsp_t rsp
);

    clbm_pkg::cmd_t cmd;
    clbm_pkg::sts_t sts;

    clbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clbm_datapath #(
        .POOL_CHUNKS(POOL_CHUNKS),
        .CHUNK_SIZE (CHUNK_SIZE),
        .NUM_LISTS  (NUM_LISTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule

FILE: src/clbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module clbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/clbm_datapath.sv
// Datapath: list descriptors, free list head, chunk metadata and element memories.
`timescale 1ns / 1ps

module clbm_datapath #(
    parameter int POOL_CHUNKS = clbm_pkg::POOL_CHUNKS_DEF,
    parameter int CHUNK_SIZE  = clbm_pkg::CHUNK_SIZE_DEF,
    parameter int NUM_LISTS   = clbm_pkg::NUM_LISTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  clbm_pkg::req_t  req,
    input  clbm_pkg::cmd_t  cmd,
    output clbm_pkg::sts_t  sts,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output clbm_pkg::rsp_t  rsp
);

    localparam int CW    = $clog2(POOL_CHUNKS);
    localparam int KW    = $clog2(POOL_CHUNKS + 1);
    localparam int FW    = $clog2(CHUNK_SIZE + 1);
    localparam int SD    = POOL_CHUNKS * CHUNK_SIZE;
    localparam int SW    = $clog2(SD);
    localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CNT_W = ($clog2(SD + 1) > clbm_pkg::LEN_W) ? $clog2(SD + 1)
                                                                : clbm_pkg::LEN_W;
    localparam int MW    = FW + 3 * KW;
    localparam logic [KW-1:0] NONE = KW'(POOL_CHUNKS);
    localparam logic [FW-1:0] CSZ  = FW'(CHUNK_SIZE);

    function automatic logic [MW-1:0] pack(input logic [FW-1:0] f, input logic [KW-1:0] n,
                                           input logic [KW-1:0] p, input logic [KW-1:0] l);
        return {f, n, p, l};
    endfunction

    function automatic logic [SW-1:0] slot(input logic [KW-1:0] c, input logic [FW-1:0] pos);
        return SW'(c[CW-1:0] * CHUNK_SIZE) + SW'(pos);
    endfunction

    logic [1:0]       op_reg;
    logic [3:0]       id_reg;
    logic [31:0]      val_reg;
    logic [9:0]       idx_reg;
    logic [KW-1:0]    first_reg [NUM_LISTS];
    logic [KW-1:0]    last_reg [NUM_LISTS];
    logic [CNT_W-1:0] count_reg [NUM_LISTS];
    logic [KW-1:0]    fh_reg;
    logic [POOL_CHUNKS-1:0] mvalid_reg;
    logic [KW-1:0]    cur_reg;
    logic [FW-1:0]    cm_fill_reg;
    logic [KW-1:0]    cm_next_reg;
    logic [KW-1:0]    cm_prev_reg;
    logic [KW-1:0]    cm_link_reg;
    logic [KW-1:0]    nc_reg;
    logic [KW-1:0]    p_reg;
    logic             fix_reg;
    logic [9:0]       local_reg;
    logic             ok_reg;
    logic [31:0]      rv_reg;
    logic             rd_valid_reg;
    logic [CW-1:0]    rd_addr_reg;
    logic             rsp_valid_reg;
    clbm_pkg::rsp_t   rsp_reg;

    logic             id_ok;
    logic [LW-1:0]    lid;
    logic [KW-1:0]    l_first;
    logic [KW-1:0]    l_last;
    logic [CNT_W-1:0] l_count;
    logic [MW-1:0]    m_q;
    logic [MW-1:0]    m_eff;
    logic [FW-1:0]    rd_fill;
    logic [KW-1:0]    rd_next;
    logic [KW-1:0]    rd_prev;
    logic [KW-1:0]    rd_link;
    logic [FW-1:0]    newfill;
    logic             get_hit;
    logic             m_we;
    logic [CW-1:0]    m_wa;
    logic [MW-1:0]    m_wd;
    logic             m_re;
    logic [CW-1:0]    m_ra;
    logic             s_we;
    logic [SW-1:0]    s_wa;
    logic [31:0]      s_wd;
    logic             s_re;
    logic [SW-1:0]    s_ra;
    logic [31:0]      s_q;

    assign id_ok   = 32'(id_reg) < NUM_LISTS;
    assign lid     = id_ok ? LW'(id_reg) : '0;
    assign l_first = first_reg[lid];
    assign l_last  = last_reg[lid];
    assign l_count = count_reg[lid];

    assign m_eff   = rd_valid_reg ? m_q
                                  : pack('0, NONE, NONE, KW'(rd_addr_reg) + KW'(1));
    assign rd_fill = m_eff[MW-1 -: FW];
    assign rd_next = m_eff[3*KW-1 -: KW];
    assign rd_prev = m_eff[2*KW-1 -: KW];
    assign rd_link = m_eff[KW-1:0];
    assign newfill = rd_fill - FW'(1);
    assign get_hit = 32'(local_reg) < 32'(rd_fill);

    always_comb
    begin
        sts.op           = op_reg;
        sts.id_ok        = id_ok;
        sts.has_last     = l_last < NONE;
        sts.has_first    = l_first < NONE;
        sts.fh_chunk     = fh_reg < NONE;
        sts.count_zero   = l_count == '0;
        sts.idx_ok       = CNT_W'(idx_reg) < l_count;
        sts.rd_full      = rd_fill >= CSZ;
        sts.rd_fill_zero = rd_fill == '0;
        sts.fix          = fix_reg;
        sts.get_hit      = get_hit;
        sts.has_next     = rd_next < NONE;
        sts.out_free     = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        m_we = 1'b0;
        m_wa = '0;
        m_wd = '0;
        m_re = 1'b0;
        m_ra = '0;
        s_we = 1'b0;
        s_wa = '0;
        s_wd = val_reg;
        s_re = 1'b0;
        s_ra = '0;
        case (cmd.code)
            clbm_pkg::CMD_PUSH_START:
            begin
                m_re = 1'b1;
                m_ra = (l_last < NONE) ? l_last[CW-1:0] : fh_reg[CW-1:0];
            end
            clbm_pkg::CMD_PUSH_FIRST:
            begin
                m_we = 1'b1;
                m_wa = fh_reg[CW-1:0];
                m_wd = pack('0, NONE, NONE, NONE);
            end
            clbm_pkg::CMD_PUSH_CHECK:
            begin
                m_re = fh_reg < NONE;
                m_ra = fh_reg[CW-1:0];
            end
            clbm_pkg::CMD_PUSH_LINK:
            begin
                m_we = 1'b1;
                m_wa = cur_reg[CW-1:0];
                m_wd = pack(cm_fill_reg, fh_reg, cm_prev_reg, cm_link_reg);
            end
            clbm_pkg::CMD_PUSH_NEW:
            begin
                m_we = 1'b1;
                m_wa = nc_reg[CW-1:0];
                m_wd = pack('0, NONE, cur_reg, NONE);
            end
            clbm_pkg::CMD_PUSH_WRITE:
            begin
                m_we = 1'b1;
                m_wa = cur_reg[CW-1:0];
                m_wd = pack(cm_fill_reg + FW'(1), cm_next_reg, cm_prev_reg, cm_link_reg);
                s_we = 1'b1;
                s_wa = slot(cur_reg, cm_fill_reg);
            end
            clbm_pkg::CMD_POP_START:
            begin
                m_re = 1'b1;
                m_ra = l_last[CW-1:0];
            end
            clbm_pkg::CMD_POP_TAKE:
            begin
                s_re = 1'b1;
                s_ra = slot(cur_reg, newfill);
                m_we = 1'b1;
                m_wa = cur_reg[CW-1:0];
                m_wd = (newfill != '0) ? pack(newfill, rd_next, rd_prev, rd_link)
                                       : pack('0, NONE, NONE, fh_reg);
            end
            clbm_pkg::CMD_POP_READ:
            begin
                m_re = fix_reg;
                m_ra = p_reg[CW-1:0];
            end
            clbm_pkg::CMD_POP_FIX:
            begin
                m_we = 1'b1;
                m_wa = p_reg[CW-1:0];
                m_wd = pack(rd_fill, NONE, rd_prev, rd_link);
            end
            clbm_pkg::CMD_GET_START:
            begin
                m_re = 1'b1;
                m_ra = l_first[CW-1:0];
            end
            clbm_pkg::CMD_GET_STEP:
            begin
                if (get_hit)
                begin
                    s_re = 1'b1;
                    s_ra = slot(cur_reg, FW'(local_reg));
                end
                else
                begin
                    m_re = rd_next < NONE;
                    m_ra = rd_next[CW-1:0];
                end
            end
            clbm_pkg::CMD_CLR_START:
            begin
                m_re = l_first < NONE;
                m_ra = l_first[CW-1:0];
            end
            clbm_pkg::CMD_CLR_STEP:
            begin
                m_we = 1'b1;
                m_wa = cur_reg[CW-1:0];
                m_wd = pack('0, NONE, NONE, fh_reg);
                m_re = rd_next < NONE;
                m_ra = rd_next[CW-1:0];
            end
            default:
            begin
                m_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                first_reg[i] <= NONE;
                last_reg[i]  <= NONE;
                count_reg[i] <= '0;
            end
            op_reg        <= '0;
            id_reg        <= '0;
            val_reg       <= '0;
            idx_reg       <= '0;
            fh_reg        <= '0;
            mvalid_reg    <= '0;
            cur_reg       <= NONE;
            cm_fill_reg   <= '0;
            cm_next_reg   <= NONE;
            cm_prev_reg   <= NONE;
            cm_link_reg   <= NONE;
            nc_reg        <= NONE;
            p_reg         <= NONE;
            fix_reg       <= 1'b0;
            local_reg     <= '0;
            ok_reg        <= 1'b0;
            rv_reg        <= '0;
            rd_valid_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (m_we)
            begin
                mvalid_reg[m_wa] <= 1'b1;
            end
            if (m_re)
            begin
                rd_valid_reg <= mvalid_reg[m_ra];
                rd_addr_reg  <= m_ra;
            end
            if (rsp_valid_reg && rsp_ready && (cmd.code != clbm_pkg::CMD_EMIT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (cmd.code)
                clbm_pkg::CMD_LOAD:
                begin
                    op_reg  <= req.operation;
                    id_reg  <= req.list_id;
                    val_reg <= req.push_value;
                    idx_reg <= req.element_index;
                    ok_reg  <= 1'b0;
                    rv_reg  <= '0;
                end
                clbm_pkg::CMD_PUSH_START:
                begin
                    cur_reg <= l_last;
                end
                clbm_pkg::CMD_PUSH_FIRST:
                begin
                    fh_reg         <= rd_link;
                    first_reg[lid] <= fh_reg;
                    last_reg[lid]  <= fh_reg;
                    cur_reg        <= fh_reg;
                    cm_fill_reg    <= '0;
                    cm_next_reg    <= NONE;
                    cm_prev_reg    <= NONE;
                    cm_link_reg    <= NONE;
                end
                clbm_pkg::CMD_PUSH_CHECK:
                begin
                    cm_fill_reg <= rd_fill;
                    cm_next_reg <= rd_next;
                    cm_prev_reg <= rd_prev;
                    cm_link_reg <= rd_link;
                end
                clbm_pkg::CMD_PUSH_LINK:
                begin
                    nc_reg <= fh_reg;
                    fh_reg <= rd_link;
                end
                clbm_pkg::CMD_PUSH_NEW:
                begin
                    last_reg[lid] <= nc_reg;
                    cur_reg       <= nc_reg;
                    cm_fill_reg   <= '0;
                    cm_next_reg   <= NONE;
                    cm_prev_reg   <= cur_reg;
                    cm_link_reg   <= NONE;
                end
                clbm_pkg::CMD_PUSH_WRITE:
                begin
                    count_reg[lid] <= l_count + CNT_W'(1);
                    ok_reg         <= 1'b1;
                end
                clbm_pkg::CMD_POP_START:
                begin
                    cur_reg <= l_last;
                end
                clbm_pkg::CMD_POP_TAKE:
                begin
                    count_reg[lid] <= l_count - CNT_W'(1);
                    ok_reg         <= 1'b1;
                    fix_reg        <= (newfill == '0) && (rd_prev < NONE);
                    if (newfill == '0)
                    begin
                        fh_reg <= cur_reg;
                        if (rd_prev < NONE)
                        begin
                            last_reg[lid] <= rd_prev;
                            p_reg         <= rd_prev;
                        end
                        else
                        begin
                            first_reg[lid] <= NONE;
                            last_reg[lid]  <= NONE;
                        end
                    end
                end
                clbm_pkg::CMD_POP_READ:
                begin
                    rv_reg <= s_q;
                end
                clbm_pkg::CMD_GET_START:
                begin
                    cur_reg   <= l_first;
                    local_reg <= idx_reg;
                end
                clbm_pkg::CMD_GET_STEP:
                begin
                    if (!get_hit)
                    begin
                        local_reg <= local_reg - 10'(rd_fill);
                        cur_reg   <= rd_next;
                    end
                end
                clbm_pkg::CMD_GET_READ:
                begin
                    rv_reg <= s_q;
                    ok_reg <= 1'b1;
                end
                clbm_pkg::CMD_CLR_START:
                begin
                    ok_reg         <= 1'b1;
                    cur_reg        <= l_first;
                    first_reg[lid] <= NONE;
                    last_reg[lid]  <= NONE;
                    count_reg[lid] <= '0;
                end
                clbm_pkg::CMD_CLR_STEP:
                begin
                    fh_reg  <= cur_reg;
                    cur_reg <= rd_next;
                end
                clbm_pkg::CMD_EMIT:
                begin
                    rsp_valid_reg       <= 1'b1;
                    rsp_reg.ok          <= ok_reg;
                    rsp_reg.read_value  <= ok_reg ? rv_reg : '0;
                    rsp_reg.list_length <= id_ok ? clbm_pkg::LEN_W'(l_count) : '0;
                end
                default:
                begin
                    fix_reg <= fix_reg;
                end
            endcase
        end
    end

    clbm_ram #(
        .WIDTH(MW),
        .DEPTH(POOL_CHUNKS)
    ) u_meta_ram (
        .clk  (clk),
        .we   (m_we),
        .waddr(m_wa),
        .wdata(m_wd),
        .re   (m_re),
        .raddr(m_ra),
        .rdata(m_q)
    );

    clbm_ram #(
        .WIDTH(32),
        .DEPTH(SD)
    ) u_store_ram (
        .clk  (clk),
        .we   (s_we),
        .waddr(s_wa),
        .wdata(s_wd),
        .re   (s_re),
        .raddr(s_ra),
        .rdata(s_q)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/clbm_ctrl.sv
// Controller state machine that sequences each operation through the datapath.
`timescale 1ns / 1ps

module clbm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  clbm_pkg::sts_t sts,
    output clbm_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_PT   = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_PN   = 4'd4;
    localparam logic [3:0] S_PN2  = 4'd5;
    localparam logic [3:0] S_PW   = 4'd6;
    localparam logic [3:0] S_Q1   = 4'd7;
    localparam logic [3:0] S_Q2   = 4'd8;
    localparam logic [3:0] S_Q3   = 4'd9;
    localparam logic [3:0] S_G1   = 4'd10;
    localparam logic [3:0] S_G2   = 4'd11;
    localparam logic [3:0] S_C1   = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.code   = clbm_pkg::CMD_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.code   = clbm_pkg::CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_EMIT;
                if (sts.id_ok)
                begin
                    case (sts.op)
                        clbm_pkg::OP_PUSH:
                        begin
                            if (sts.has_last)
                            begin
                                cmd.code   = clbm_pkg::CMD_PUSH_START;
                                state_next = S_P1;
                            end
                            else if (sts.fh_chunk)
                            begin
                                cmd.code   = clbm_pkg::CMD_PUSH_START;
                                state_next = S_PT;
                            end
                        end
                        clbm_pkg::OP_POP:
                        begin
                            if (!sts.count_zero && sts.has_last)
                            begin
                                cmd.code   = clbm_pkg::CMD_POP_START;
                                state_next = S_Q1;
                            end
                        end
                        clbm_pkg::OP_GET:
                        begin
                            if (sts.idx_ok && sts.has_first)
                            begin
                                cmd.code   = clbm_pkg::CMD_GET_START;
                                state_next = S_G1;
                            end
                        end
                        default:
                        begin
                            cmd.code = clbm_pkg::CMD_CLR_START;
                            if (sts.has_first)
                            begin
                                state_next = S_C1;
                            end
                        end
                    endcase
                end
            end
            S_PT:
            begin
                cmd.code   = clbm_pkg::CMD_PUSH_FIRST;
                state_next = S_PW;
            end
            S_P1:
            begin
                cmd.code = clbm_pkg::CMD_PUSH_CHECK;
                if (!sts.rd_full)
                begin
                    state_next = S_PW;
                end
                else if (sts.fh_chunk)
                begin
                    state_next = S_PN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_PN:
            begin
                cmd.code   = clbm_pkg::CMD_PUSH_LINK;
                state_next = S_PN2;
            end
            S_PN2:
            begin
                cmd.code   = clbm_pkg::CMD_PUSH_NEW;
                state_next = S_PW;
            end
            S_PW:
            begin
                cmd.code   = clbm_pkg::CMD_PUSH_WRITE;
                state_next = S_EMIT;
            end
            S_Q1:
            begin
                if (sts.rd_fill_zero)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.code   = clbm_pkg::CMD_POP_TAKE;
                    state_next = S_Q2;
                end
            end
            S_Q2:
            begin
                cmd.code   = clbm_pkg::CMD_POP_READ;
                state_next = sts.fix ? S_Q3 : S_EMIT;
            end
            S_Q3:
            begin
                cmd.code   = clbm_pkg::CMD_POP_FIX;
                state_next = S_EMIT;
            end
            S_G1:
            begin
                if (sts.get_hit)
                begin
                    cmd.code   = clbm_pkg::CMD_GET_STEP;
                    state_next = S_G2;
                end
                else if (sts.has_next)
                begin
                    cmd.code = clbm_pkg::CMD_GET_STEP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_G2:
            begin
                cmd.code   = clbm_pkg::CMD_GET_READ;
                state_next = S_EMIT;
            end
            S_C1:
            begin
                cmd.code = clbm_pkg::CMD_CLR_STEP;
                if (!sts.has_next)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.code   = clbm_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
